@@ sv/decaying_random_shake_offset_top_assert.svh @@
// Assertion macros for the decaying random shake offset block.
// Used by the port checker; depends on clk and rst_n being in scope.
`ifndef DECAYING_RANDOM_SHAKE_OFFSET_TOP_ASSERT_SVH
`define DECAYING_RANDOM_SHAKE_OFFSET_TOP_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define DRSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset.
`define DRSO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/drso_pkg.sv @@
// Shared types and constants for the decaying random shake offset block.
// No dependencies; imported by every module of the block.
package drso_pkg;

  // Field and register widths.
  localparam int STRENGTH_W = 10;
  localparam int DUR_W      = 16;
  localparam int SEED_W     = 32;
  localparam int OFS_W      = 11;
  localparam int PROD_W     = STRENGTH_W + DUR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Shared divider geometry: 32-bit dividend, 16-bit divisor, two bits a cycle.
  localparam int DIVD_W           = 32;
  localparam int DIVS_W           = 16;
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = DIVD_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

  // Linear congruential generator constants.
  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd2;

  // Input command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AMP_GO,
    ST_AMP_WAIT,
    ST_AMP_CHK,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_DONE
  } drso_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_start;
    logic div_sel_mod;
    logic cap_amp;
    logic lcg;
    logic cap_x;
    logic cap_y;
    logic out_load;
  } drso_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shake_idle;
    logic amp_zero;
    logic div_done;
  } drso_sts_t;

endpackage

@@ sv/decaying_random_shake_offset_top.sv @@
// An item whose shake is idle goes straight to the result; otherwise the shared
// divider works out the amplitude and, if it is not zero, makes two more passes
// for the offsets, at two quotient bits a cycle.
// Throughput: one item at a time; the next item is taken once the result has
// entered the output register, which holds it until it is taken.
// Reset: synchronous, active low; state resets, payload registers do not.
module decaying_random_shake_offset_top
  import drso_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [DUR_W-1:0]        in_elapsed_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OFS_W-1:0] out_offset_x,
  output logic signed [OFS_W-1:0] out_offset_y
);

  drso_cmd_t cmd;
  drso_sts_t sts;

  // Sequencer.
  drso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  drso_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_elapsed_time (in_elapsed_time),
    .cmd             (cmd),
    .sts             (sts),
    .out_offset_x    (out_offset_x),
    .out_offset_y    (out_offset_y)
  );

endmodule

@@ sv/drso_div.sv @@
// Iterative restoring divider giving quotient and remainder, two bits a cycle.
// Depends on drso_pkg for its widths.
module drso_div
  import drso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic [DIVS_W-1:0] remainder,
  output logic              done
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVS_W:0]      trial;
  logic                 qbit;

  // Shift in dividend bits, subtract the divisor where it fits.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    qbit     = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
        trial = {rem_nxt, quo_nxt[DIVD_W-1]};
        if (trial >= {1'b0, dvs_r}) begin
          trial = trial - {1'b0, dvs_r};
          qbit  = 1'b1;
        end else begin
          qbit  = 1'b0;
        end
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_nxt[DIVD_W-2:0], qbit};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

@@ sv/drso_dp.sv @@
// Datapath: configuration registers, shake state, generator and offset results.
// Depends on drso_pkg and instantiates the shared divider drso_div.
module drso_dp
  import drso_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_cmd,
  input  logic [DUR_W-1:0]        in_elapsed_time,
  input  drso_cmd_t               cmd,
  output drso_sts_t               sts,
  output logic signed [OFS_W-1:0] out_offset_x,
  output logic signed [OFS_W-1:0] out_offset_y
);

  // Configuration registers.
  logic [STRENGTH_W-1:0] strength_r, strength_nxt;
  logic [DUR_W-1:0]      duration_r, duration_nxt;
  logic [SEED_W-1:0]     seed_r, seed_nxt;
  // Shake state.
  logic [STRENGTH_W-1:0] hs_r, hs_nxt;
  logic [DUR_W-1:0]      hd_r, hd_nxt;
  logic [DUR_W-1:0]      tl_r, tl_nxt;
  logic [SEED_W-1:0]     gen_r, gen_nxt;
  // Working values.
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [STRENGTH_W-1:0] amp_r, amp_nxt;
  logic [OFS_W-1:0]      x_r, x_nxt;
  logic [OFS_W-1:0]      y_r, y_nxt;
  logic [OFS_W-1:0]      ox_r, ox_nxt;
  logic [OFS_W-1:0]      oy_r, oy_nxt;

  logic [DIVD_W-1:0]     div_dividend;
  logic [DIVS_W-1:0]     div_divisor;
  logic [DIVD_W-1:0]     div_quo;
  logic [DIVS_W-1:0]     div_rem;
  logic                  div_done;
  logic [OFS_W-1:0]      range;
  logic [OFS_W-1:0]      centred;

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    strength_nxt = strength_r;
    duration_nxt = duration_r;
    seed_nxt     = seed_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STRENGTH: strength_nxt = cfg_wdata[STRENGTH_W-1:0];
        REG_DURATION: duration_nxt = cfg_wdata[DUR_W-1:0];
        REG_SEED:     seed_nxt     = cfg_wdata[SEED_W-1:0];
        default:      ;
      endcase
    end
  end

  // Start latches the registers; a tick lowers the time left, saturating at zero.
  always_comb begin
    hs_nxt  = hs_r;
    hd_nxt  = hd_r;
    tl_nxt  = tl_r;
    gen_nxt = gen_r;
    if (cmd.accept) begin
      if (in_cmd == CMD_START) begin
        hs_nxt  = strength_r;
        hd_nxt  = duration_r;
        tl_nxt  = duration_r;
        gen_nxt = (seed_r != '0) ? seed_r : SEED_W'(1);
      end else begin
        tl_nxt  = (in_elapsed_time >= tl_r) ? '0 : tl_r - in_elapsed_time;
      end
    end else if (cmd.lcg) begin
      gen_nxt = gen_r * LCG_MUL + LCG_ADD;
    end
  end

  // The divider serves the amplitude and both modulo reductions.
  assign range        = {amp_r, 1'b1};
  assign div_dividend = cmd.div_sel_mod ? gen_r : {{(DIVD_W-PROD_W){1'b0}}, prod_r};
  assign div_divisor  = cmd.div_sel_mod ? {{(DIVS_W-OFS_W){1'b0}}, range} : hd_r;
  assign centred      = div_rem[OFS_W-1:0] - {1'b0, amp_r};

  drso_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Product, amplitude, offsets and the output register.
  always_comb begin
    prod_nxt = cmd.mul ? hs_r * tl_r : prod_r;
    amp_nxt  = cmd.cap_amp ? div_quo[STRENGTH_W-1:0] : amp_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (cmd.accept) begin
      x_nxt = '0;
      y_nxt = '0;
    end else begin
      if (cmd.cap_x) x_nxt = centred;
      if (cmd.cap_y) y_nxt = centred;
    end
    ox_nxt = cmd.out_load ? x_r : ox_r;
    oy_nxt = cmd.out_load ? y_r : oy_r;
  end

  // Registers with a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= '0;
      duration_r <= '0;
      seed_r     <= SEED_W'(1);
      hs_r       <= '0;
      hd_r       <= '0;
      tl_r       <= '0;
      gen_r      <= SEED_W'(1);
    end else begin
      strength_r <= strength_nxt;
      duration_r <= duration_nxt;
      seed_r     <= seed_nxt;
      hs_r       <= hs_nxt;
      hd_r       <= hd_nxt;
      tl_r       <= tl_nxt;
      gen_r      <= gen_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    amp_r  <= amp_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
  end

  assign sts.shake_idle = (hs_r == '0) || (hd_r == '0) || (tl_r == '0);
  assign sts.amp_zero   = (amp_r == '0);
  assign sts.div_done   = div_done;

  assign out_offset_x = ox_r;
  assign out_offset_y = oy_r;

endmodule

@@ sv/drso_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
// Depends on drso_pkg for the state type and the command and status structs.
module drso_ctrl
  import drso_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  drso_sts_t sts,
  output drso_cmd_t cmd
);

  drso_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.shake_idle) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_AMP_GO;
        end
      end
      ST_AMP_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_AMP_WAIT;
      end
      ST_AMP_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_amp = 1'b1;
          state_nxt   = ST_AMP_CHK;
        end
      end
      ST_AMP_CHK: begin
        if (sts.amp_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.lcg   = 1'b1;
          state_nxt = ST_X_GO;
        end
      end
      ST_X_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_mod = 1'b1;
        state_nxt       = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        cmd.div_sel_mod = 1'b1;
        if (sts.div_done) begin
          cmd.cap_x = 1'b1;
          cmd.lcg   = 1'b1;
          state_nxt = ST_Y_GO;
        end
      end
      ST_Y_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_mod = 1'b1;
        state_nxt       = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        cmd.div_sel_mod = 1'b1;
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/drso_chk.sv @@
// Port checker for the decaying random shake offset block, bound to the top level.
// Depends on drso_pkg and the assertion macro header.
`include "decaying_random_shake_offset_top_assert.svh"

module drso_chk
  import drso_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OFS_W-1:0] out_offset_x,
  input logic signed [OFS_W-1:0] out_offset_y
);

  // A result waiting to be taken stays offered.
  `DRSO_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its offsets.
  `DRSO_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_offset_x) && $stable(out_offset_y), "result changed while stalled")

  // Once an item is taken the block is busy with it in the next cycle.
  `DRSO_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "second item taken while busy")

  // Reset leaves no result on offer.
  `DRSO_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind decaying_random_shake_offset_top drso_chk u_drso_chk (.*);

@@ dv/shake_offset_checker.sv @@
// Checker for the decaying random shake offset block: it watches the register port and both
// item channels, predicts every offset pair and compares it with what the block delivers.
// Depends on drso_pkg for widths, register indexes, command codes and generator constants.
module shake_offset_checker
  import drso_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [DUR_W-1:0]        in_elapsed_time,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OFS_W-1:0] out_offset_x,
  input  logic signed [OFS_W-1:0] out_offset_y,
  output int                      error_count,
  output int                      pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OFS_W-1:0] x;
    logic [OFS_W-1:0] y;
  } shake_offsets_t;

  // Register shadows, as last written.
  logic [STRENGTH_W-1:0] reg_strength;
  logic [DUR_W-1:0]      reg_duration;
  logic [SEED_W-1:0]     reg_seed;

  // Shake state, with the registers as latched at the last start.
  logic [DUR_W-1:0]      left_ms;
  logic [SEED_W-1:0]     lcg_word;
  logic [STRENGTH_W-1:0] held_strength;
  logic [DUR_W-1:0]      held_duration;

  shake_offsets_t offsets_q[$];

  // One generator step, reduced to the range -amp..amp.
  function automatic logic [OFS_W-1:0] next_offset(input logic [31:0] amp);
    logic [31:0] span;
    logic [31:0] centred;
    span     = amp * 2 + 1;
    lcg_word = lcg_word * LCG_MUL + LCG_ADD;
    centred  = lcg_word % span - amp;
    return centred[OFS_W-1:0];
  endfunction

  // Advances the shake by one item and works out the offsets it yields.
  task automatic advance_shake(input logic cmd, input logic [DUR_W-1:0] elapsed,
                               output shake_offsets_t res);
    logic [DUR_W-1:0] step;
    logic [31:0]      amp;
    if (cmd == CMD_START) begin
      held_strength = reg_strength;
      held_duration = reg_duration;
      left_ms       = reg_duration;
      lcg_word      = (reg_seed != '0) ? reg_seed : 32'd1;
      step          = '0;
    end else begin
      step = elapsed;
    end
    if (left_ms != '0)
      left_ms = (step >= left_ms) ? '0 : left_ms - step;
    res = '0;
    if (held_strength != '0 && held_duration != '0 && left_ms != '0) begin
      amp = (32'(held_strength) * 32'(left_ms)) / 32'(held_duration);
      if (amp != 0) begin
        res.x = next_offset(amp);
        res.y = next_offset(amp);
      end
    end
  endtask

  // Prediction on each accepted input item, comparison on each accepted result.
  always @(posedge clk) begin
    shake_offsets_t predicted;
    shake_offsets_t oldest;
    if (!rst_n) begin
      reg_strength  = '0;
      reg_duration  = '0;
      reg_seed      = 32'd1;
      left_ms       = '0;
      lcg_word      = 32'd1;
      held_strength = '0;
      held_duration = '0;
      offsets_q.delete();
      error_count   = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_STRENGTH: reg_strength = cfg_wdata[STRENGTH_W-1:0];
          REG_DURATION: reg_duration = cfg_wdata[DUR_W-1:0];
          REG_SEED:     reg_seed     = cfg_wdata[SEED_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_shake(in_cmd, in_elapsed_time, predicted);
        offsets_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (offsets_q.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected result: x=%0d y=%0d", out_offset_x, out_offset_y);
          error_count++;
        end else begin
          oldest = offsets_q.pop_front();
          if (oldest.x !== out_offset_x || oldest.y !== out_offset_y) begin
            if (error_count < MAX_REPORTS)
              $display("offset mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       $signed(oldest.x), $signed(oldest.y), out_offset_x, out_offset_y);
            error_count++;
          end
        end
      end
    end
    pending = offsets_q.size();
  end

endmodule

@@ dv/decaying_random_shake_offset_top_test.sv @@
// Top of the shake offset testbench: clock, reset, register writes, item stimulus,
// receiver stalls, watchdog and final verdict.
// Depends on drso_pkg, the block under test and shake_offset_checker.
module decaying_random_shake_offset_top_test;
  import drso_pkg::*;

  localparam int ITEM_TARGET    = 800;
  localparam int MAX_GAP        = 16;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                    clk;
  logic                    rst_n           = 1'b0;
  logic                    cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index       = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata       = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic                    in_cmd          = CMD_TICK;
  logic [DUR_W-1:0]        in_elapsed_time = '0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic signed [OFS_W-1:0] out_offset_x;
  logic signed [OFS_W-1:0] out_offset_y;

  int error_count;
  int pending;
  int items_sent    = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  bit no_idle       = 1'b0;
  bit held_off      = 1'b0;

  decaying_random_shake_offset_top dut (.*);

  shake_offset_checker offset_check (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offers one item after a random gap and returns once it is accepted.
  task automatic send_item(input logic cmd, input logic [DUR_W-1:0] elapsed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_elapsed_time <= elapsed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every predicted result has been delivered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes a full register set once the block has gone quiet.
  task automatic load_shake(input logic [STRENGTH_W-1:0] strength,
                            input logic [DUR_W-1:0] duration,
                            input logic [SEED_W-1:0] seed, input bit spare);
    wait_idle();
    write_reg(REG_STRENGTH, 32'(strength));
    write_reg(REG_DURATION, 32'(duration));
    write_reg(REG_SEED, seed);
    if (spare)
      write_reg(REG_SPARE, $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly short ticks so that a shake decays over many items.
  function automatic logic [DUR_W-1:0] pick_elapsed(input logic [DUR_W-1:0] duration);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return DUR_W'($urandom_range(0, 65535));
    else if (sel == 1)
      return '0;
    else
      return DUR_W'($urandom_range(0, duration / 20 + 1));
  endfunction

  // Receiver: random stalls per item and one long hold-off while items keep coming.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_taken >= HOLD_AFTER && in_valid) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed corner cases, then random shakes.
  initial begin
    int directed_items;
    int n_items;
    bit restart;
    logic                  cmd;
    logic [STRENGTH_W-1:0] strength;
    logic [DUR_W-1:0]      duration;
    logic [SEED_W-1:0]     seed;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: a tick before any start, then a zero-strength start.
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_START, '0);

    // Full strength and duration, seed zero; elapsed ignored on start, then saturation.
    load_shake('1, '1, '0, 1'b1);
    send_item(CMD_START, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'h0001);
    send_item(CMD_TICK, 16'h5555);
    send_item(CMD_TICK, 16'hAAAA);
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'h0005);

    // Amplitude of one that rounds down to zero after the first tick.
    load_shake(10'd1, 16'd1000, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_START, '0);
    send_item(CMD_TICK, 16'd1);
    send_item(CMD_TICK, 16'd999);

    // Shortest shake at full strength: widest offsets, then over.
    load_shake('1, 16'd1, 32'h8000_0001, 1'b0);
    send_item(CMD_START, 16'h1234);
    send_item(CMD_TICK, 16'd0);
    send_item(CMD_TICK, 16'd1);

    // Zero duration keeps the shake idle.
    load_shake(10'd1000, 16'd0, 32'd1, 1'b0);
    send_item(CMD_START, '0);
    send_item(CMD_TICK, 16'd3);

    // Register writes in mid-shake only count from the next start.
    load_shake(10'd600, 16'd3000, $urandom, 1'b0);
    send_item(CMD_START, '0);
    send_item(CMD_TICK, 16'd100);
    wait_idle();
    write_reg(REG_STRENGTH, '0);
    write_reg(REG_DURATION, 32'd7);
    cfg_wr_en <= 1'b0;
    send_item(CMD_TICK, 16'd100);
    send_item(CMD_TICK, 16'd100);
    send_item(CMD_START, 16'd100);

    // Random shakes with random register settings, extremes included.
    directed_items = items_sent;
    while (items_sent < directed_items + ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       strength = '0;
        1:       strength = '1;
        2:       strength = 10'd1;
        default: strength = STRENGTH_W'($urandom_range(2, 1022));
      endcase
      case ($urandom_range(0, 7))
        0:       duration = '0;
        1:       duration = '1;
        2:       duration = 16'd1;
        default: duration = DUR_W'($urandom_range(2, 4000));
      endcase
      case ($urandom_range(0, 7))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      load_shake(strength, duration, seed, $urandom_range(0, 7) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      restart = ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(8, 40);
      for (int k = 0; k < n_items; k++) begin
        cmd = ((k == 0 && restart) || $urandom_range(0, 19) == 0) ? CMD_START : CMD_TICK;
        send_item(cmd, pick_elapsed(duration));
      end
    end

    // Let every outstanding result arrive, then give the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/drso_pkg.sv
sv/drso_div.sv
sv/drso_dp.sv
sv/drso_ctrl.sv
sv/decaying_random_shake_offset_top.sv
sv/drso_chk.sv
dv/shake_offset_checker.sv
dv/decaying_random_shake_offset_top_test.sv
